// File: hw/rtl/hotkey_chord_matcher_defines.svh
`ifndef HOTKEY_CHORD_MATCHER_DEFINES_SVH
`define HOTKEY_CHORD_MATCHER_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define HCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define HCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/hcm_pkg.sv
`default_nettype none

package hcm_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_BIND   = 2'd1,
		OP_REBIND = 2'd2,
		OP_FIND   = 2'd3
	} hcm_op_t;

	// Register map of the configuration port; the last one lies past the list.
	typedef enum logic [1:0] {
		REG_LEADER_KEY  = 2'd0,
		REG_LEADER_MODS = 2'd1,
		REG_GOTO_CODE   = 2'd2,
		REG_SPARE       = 2'd3
	} hcm_reg_t;

	localparam logic [5:0] MOD_CTRL  = 6'd1;
	localparam logic [5:0] MOD_SHIFT = 6'd2;
	localparam logic [5:0] MOD_CTRL_SHIFT = 6'd3;

	localparam logic [8:0] KEY_MODS_LO = 9'd340;
	localparam logic [8:0] KEY_MODS_HI = 9'd347;
	localparam logic [8:0] KEY_CAPS    = 9'd280;
	localparam logic [8:0] KEY_NUM     = 9'd282;
	localparam logic [8:0] KEY_KP_0    = 9'd320;
	localparam logic [8:0] KEY_KP_9    = 9'd329;
	localparam logic [8:0] KEY_0       = 9'd48;
	localparam logic [8:0] KEY_9       = 9'd57;
	localparam logic [8:0] KEY_A       = 9'd65;
	localparam logic [8:0] KEY_Z       = 9'd90;
	localparam logic [8:0] KEY_LC_A    = 9'd97;
	localparam logic [8:0] KEY_LC_Z    = 9'd122;
	localparam logic [8:0] KEY_CASE    = 9'd32;
	localparam logic [8:0] KEY_PERCENT = 9'd37;
	localparam logic [8:0] KEY_DQUOTE  = 9'd34;
	localparam logic [8:0] KEY_PIPE    = 9'd124;
	localparam logic [8:0] KEY_QMARK   = 9'd63;
	localparam logic [8:0] KEY_PLUS    = 9'd43;
	localparam logic [8:0] KEY_5       = 9'd53;
	localparam logic [8:0] KEY_QUOTE   = 9'd39;
	localparam logic [8:0] KEY_BSLASH  = 9'd92;
	localparam logic [8:0] KEY_SLASH   = 9'd47;
	localparam logic [8:0] KEY_EQUAL   = 9'd61;

	typedef struct packed {
		logic [1:0] action;
		logic [8:0] key_code;
		logic [5:0] modifiers;
		logic       needs_prefix;
		logic [5:0] bind_action;
	} hcm_item_t;

	typedef struct packed {
		logic [5:0] result_action;
		logic [3:0] window_number;
		logic       leader_armed;
		logic       found;
		logic [8:0] found_key;
		logic [5:0] found_mods;
		logic       found_prefix;
		logic       dropped;
	} hcm_result_t;

	typedef struct packed {
		logic [8:0] key;
		logic [5:0] mods;
		logic       prefix;
		logic [5:0] act;
	} hcm_entry_t;

	typedef struct packed {
		logic [8:0] key;
		logic [5:0] mods;
	} hcm_chord_t;

	// Fold lower-case letters and shifted punctuation onto their base key.
	function automatic hcm_chord_t hcm_normalise(input logic [8:0] key, input logic [5:0] mods);
		hcm_chord_t c;
		c.key  = key;
		c.mods = mods;
		if (key >= KEY_LC_A && key <= KEY_LC_Z) begin
			c.key = key - KEY_CASE;
		end else if (key == KEY_PERCENT) begin
			c.key = KEY_5;
			c.mods = mods | MOD_SHIFT;
		end else if (key == KEY_DQUOTE) begin
			c.key = KEY_QUOTE;
			c.mods = mods | MOD_SHIFT;
		end else if (key == KEY_PIPE) begin
			c.key = KEY_BSLASH;
			c.mods = mods | MOD_SHIFT;
		end else if (key == KEY_QMARK) begin
			c.key = KEY_SLASH;
			c.mods = mods | MOD_SHIFT;
		end else if (key == KEY_PLUS) begin
			c.key = KEY_EQUAL;
			c.mods = mods | MOD_SHIFT;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hotkey_chord_matcher.sv
`default_nettype none

// Hotkey chord matcher. Pulse start with an item while busy is low; the
// block raises busy and later shows exactly one result for a single cycle
// with done high. The receiver cannot stall, so sample result whenever done
// is high. Lookups of bare modifier keys, the leader chord and leader plus
// digit finish without a table walk, and a bind appends straight to the
// table. Every other item walks the binding table through one memory with
// a write port and a registered read port, one entry at a time (address,
// then compare on the registered read). A rebind walks the table twice and
// copies the last entry into the hole for each removed entry, then appends
// the new binding. The table needs no clearing after reset: only entries
// below the fill count are ever used. Configuration sits behind an
// APB-style port at byte addresses 0 (leader key), 4 (leader modifier bits)
// and 8 (goto action code); write only while busy is low. Writing the
// leader key (nonzero) or the leader modifier bits disarms the leader; a
// leader key write of zero is ignored.
module hotkey_chord_matcher (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire hcm_pkg::hcm_item_t  item,
	output logic                     done,
	output hcm_pkg::hcm_result_t     result,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	import hcm_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_RD     = 7'b0000010,
		S_CHK    = 7'b0000100,
		S_MVRD   = 7'b0001000,
		S_MVWR   = 7'b0010000,
		S_APPEND = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t      state_q;
	hcm_item_t   item_q;       // chord already normalised for bind and rebind
	logic        pre_q;        // lookup scans prefix entries (leader was armed)
	logic        phase_q;      // rebind: 0 remove by action, 1 remove by chord
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic        armed_q;
	logic [3:0]  win_q;
	logic        fb_q;         // Ctrl+Shift letter fallback seen
	logic [5:0]  fb_act_q;
	logic [5:0]  res_act_q;
	logic        found_q;
	hcm_entry_t  found_ent_q;
	logic        drop_q;
	logic [8:0]  leader_key_q;
	logic [5:0]  lead_mods_q;
	logic [5:0]  goto_code_q;

	hcm_entry_t  bind_mem [TABLE_DEPTH];
	hcm_entry_t  ent_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W-1:0] mem_raddr;
	hcm_entry_t       mem_wdata;
	logic [CNT_W-1:0] last_idx;

	// Input decode: the lookup cases that skip the table walk, and the folded chord.
	logic        bare_mod;
	logic        leader_hit;
	logic        is_digit;
	logic [3:0]  digit;
	logic        digit_sel;
	logic        scan_pre;
	hcm_chord_t  norm;
	hcm_item_t   item_in;
	logic        cfg_wr;

	// Shared entry compare.
	logic [5:0]  eff_mods;
	logic        hit_prefix;
	logic        hit_exact;
	logic        hit_fb;
	logic        hit_act;
	logic        hit_chord;
	logic        hit_remove;
	logic        chk_stop;
	logic        chk_hold;

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_DONE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	assign bare_mod = (item.key_code >= KEY_MODS_LO && item.key_code <= KEY_MODS_HI) ||
		item.key_code == KEY_CAPS || item.key_code == KEY_NUM;
	assign leader_hit = (item.key_code == leader_key_q) && (item.modifiers == lead_mods_q);
	assign norm = hcm_normalise(item.key_code, item.modifiers);

	always_comb begin
		digit    = 4'd0;
		is_digit = 1'b0;
		if (item.key_code >= KEY_0 && item.key_code <= KEY_9) begin
			digit    = 4'(item.key_code - KEY_0);
			is_digit = 1'b1;
		end else if (item.key_code >= KEY_KP_0 && item.key_code <= KEY_KP_9) begin
			digit    = 4'(item.key_code - KEY_KP_0);
			is_digit = 1'b1;
		end
	end

	// Armed lookup: a digit with no modifiers beyond the leader's picks a
	// window, any other key but a bare modifier or the leader scans the prefix entries.
	assign digit_sel = item.action == OP_LOOKUP && !bare_mod && !leader_hit && armed_q &&
		is_digit && (item.modifiers & ~lead_mods_q) == 6'd0;
	assign scan_pre  = item.action == OP_LOOKUP && !bare_mod && !leader_hit && armed_q &&
		!digit_sel;

	// Bind and rebind store the folded chord.
	always_comb begin
		item_in = item;
		if (item.action == OP_BIND || item.action == OP_REBIND) begin
			item_in.key_code  = norm.key;
			item_in.modifiers = norm.mods;
		end
	end

	always_comb begin
		eff_mods = item_q.modifiers & ~lead_mods_q;
		if (!ent_q.mods[1] && ent_q.key >= KEY_A && ent_q.key <= KEY_Z) begin
			eff_mods = eff_mods & ~MOD_SHIFT;
		end
	end

	assign hit_prefix = ent_q.prefix && ent_q.key == item_q.key_code &&
		(ent_q.mods == item_q.modifiers || ent_q.mods == eff_mods);
	assign hit_exact  = !ent_q.prefix && ent_q.key == item_q.key_code &&
		ent_q.mods == item_q.modifiers;
	assign hit_fb     = (item_q.modifiers & MOD_CTRL_SHIFT) == MOD_CTRL_SHIFT &&
		item_q.key_code >= KEY_A && item_q.key_code <= KEY_Z &&
		!ent_q.prefix && ent_q.key == item_q.key_code && ent_q.mods == MOD_CTRL_SHIFT;
	assign hit_act    = ent_q.act == item_q.bind_action;
	assign hit_chord  = ent_q.key == item_q.key_code && ent_q.mods == item_q.modifiers &&
		ent_q.prefix == item_q.needs_prefix;
	assign hit_remove = phase_q ? hit_chord : hit_act;

	// Stop the walk on a firing entry or a found action; hold the index on a removal.
	always_comb begin
		case (item_q.action)
			OP_LOOKUP: chk_stop = pre_q ? hit_prefix : hit_exact;
			OP_FIND:   chk_stop = hit_act;
			default:   chk_stop = 1'b0;
		endcase
	end
	assign chk_hold = (item_q.action == OP_REBIND) && hit_remove;

	// Table port: read the scan index, or the last entry when filling a hole.
	assign last_idx  = CNT_W'(cnt_q - 1'b1);
	assign mem_raddr = (state_q == S_MVRD) ? last_idx[IDX_W-1:0] : idx_q[IDX_W-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = ent_q;
		if (state_q == S_MVWR) begin
			mem_we = 1'b1;
		end else if (state_q == S_APPEND && cnt_q < CNT_W'(TABLE_DEPTH)) begin
			mem_we           = 1'b1;
			mem_waddr        = cnt_q[IDX_W-1:0];
			mem_wdata.key    = item_q.key_code;
			mem_wdata.mods   = item_q.modifiers;
			mem_wdata.prefix = item_q.needs_prefix;
			mem_wdata.act    = item_q.bind_action;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bind_mem[mem_waddr] <= mem_wdata;
		end
		ent_q <= bind_mem[mem_raddr];
	end

	always_comb begin
		result.result_action = res_act_q;
		result.window_number = win_q;
		result.leader_armed  = armed_q;
		result.found         = found_q;
		result.found_key     = found_ent_q.key;
		result.found_mods    = found_ent_q.mods;
		result.found_prefix  = found_ent_q.prefix;
		result.dropped       = drop_q;
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LEADER_KEY:  prdata = 32'(leader_key_q);
			REG_LEADER_MODS: prdata = 32'(lead_mods_q);
			REG_GOTO_CODE:   prdata = 32'(goto_code_q);
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			armed_q       <= 1'b0;
			win_q         <= 4'd0;
			leader_key_q  <= 9'd66;
			lead_mods_q   <= 6'd1;
			goto_code_q   <= 6'd1;
			idx_q         <= '0;
			phase_q       <= 1'b0;
			pre_q         <= 1'b0;
			fb_q          <= 1'b0;
		end else begin
			// Register writes; a zero leader key is ignored.
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_LEADER_KEY: begin
						if (pwdata[8:0] != 9'd0) begin
							leader_key_q <= pwdata[8:0];
							armed_q      <= 1'b0;
						end
					end
					REG_LEADER_MODS: begin
						lead_mods_q <= pwdata[5:0];
						armed_q     <= 1'b0;
					end
					REG_GOTO_CODE: goto_code_q <= pwdata[5:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q      <= item_in;
						idx_q       <= '0;
						phase_q     <= 1'b0;
						pre_q       <= scan_pre;
						fb_q        <= 1'b0;
						res_act_q   <= digit_sel ? goto_code_q : 6'd0;
						found_q     <= 1'b0;
						found_ent_q <= '0;
						drop_q      <= 1'b0;
						case (item.action)
							OP_LOOKUP: begin
								if (bare_mod) begin
									state_q <= S_DONE;
								end else if (leader_hit) begin
									armed_q <= ~armed_q;
									state_q <= S_DONE;
								end else if (armed_q) begin
									// Armed: disarm whatever follows.
									armed_q <= 1'b0;
									if (digit_sel) begin
										win_q   <= digit;
										state_q <= S_DONE;
									end else begin
										state_q <= S_RD;
									end
								end else begin
									state_q <= S_RD;
								end
							end
							OP_BIND, OP_REBIND: begin
								state_q <= (item.action == OP_BIND) ? S_APPEND : S_RD;
							end
							default: state_q <= S_RD;
						endcase
					end
				end
				S_RD: begin
					if (idx_q >= cnt_q) begin
						// End of the walk.
						case (item_q.action)
							OP_LOOKUP: begin
								if (fb_q) begin
									res_act_q <= fb_act_q;
								end
								state_q <= S_DONE;
							end
							OP_REBIND: begin
								idx_q   <= '0;
								phase_q <= 1'b1;
								state_q <= phase_q ? S_APPEND : S_RD;
							end
							default: state_q <= S_DONE;
						endcase
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					// Hold the index on a removal and fill the hole from the end.
					state_q <= chk_stop ? S_DONE : (chk_hold ? S_MVRD : S_RD);
					if (!chk_hold) begin
						idx_q <= CNT_W'(idx_q + 1'b1);
					end
					case (item_q.action)
						OP_LOOKUP: begin
							if (chk_stop) begin
								res_act_q <= ent_q.act;
							end else if (!pre_q && hit_fb && !fb_q) begin
								fb_q     <= 1'b1;
								fb_act_q <= ent_q.act;
							end
						end
						OP_FIND: begin
							if (chk_stop) begin
								found_q     <= 1'b1;
								found_ent_q <= ent_q;
							end
						end
						default: ;
					endcase
				end
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					cnt_q   <= last_idx;
					state_q <= S_RD;
				end
				S_APPEND: begin
					if (cnt_q < CNT_W'(TABLE_DEPTH)) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
					end else begin
						drop_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "hotkey_chord_matcher_defines.svh"

	`HCM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
	`HCM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`HCM_ASSERT_NEXT(a_done_idle, done, !busy, "block not idle after result")
	`HCM_ASSERT_NOW(a_move_inside, state_q == S_MVWR, idx_q < cnt_q, "hole fill outside table")
	`HCM_ASSERT_NOW(a_drop_op, done && result.dropped, item_q.action == OP_BIND || item_q.action == OP_REBIND, "drop flagged on lookup or find")

endmodule

`default_nettype wire
